FILE: hw/rtl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg: shared constants, codes and the product schedule
// Holds the command codes, the queue depth and the table that steers the
// shared multiplier through the cross and dot products.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int NUM_STEPS      = 24;
  localparam int NUM_RES        = 10;
  localparam int DIV_BITS       = 31;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_LOAD_C = 2'd2,
    CMD_RAY    = 2'd3
  } cmd_e;

  // Operand vectors held per ray request
  localparam logic [1:0] VEC_DIR = 2'd0;
  localparam logic [1:0] VEC_E1  = 2'd1;
  localparam logic [1:0] VEC_E2  = 2'd2;
  localparam logic [1:0] VEC_S   = 2'd3;

  // Second multiplier operand sources
  localparam logic [1:0] B_E2 = 2'd0;
  localparam logic [1:0] B_E1 = 2'd1;
  localparam logic [1:0] B_P  = 2'd2;
  localparam logic [1:0] B_Q  = 2'd3;

  // Result register slots
  localparam logic [3:0] DST_P   = 4'd0;
  localparam logic [3:0] DST_Q   = 4'd3;
  localparam logic [3:0] DST_DET = 4'd6;
  localparam logic [3:0] DST_UN  = 4'd7;
  localparam logic [3:0] DST_VN  = 4'd8;
  localparam logic [3:0] DST_TN  = 4'd9;

  localparam logic [1:0] CX = 2'd0;
  localparam logic [1:0] CY = 2'd1;
  localparam logic [1:0] CZ = 2'd2;

  typedef struct packed {
    logic [1:0] a_vec;
    logic [1:0] a_c;
    logic [1:0] b_src;
    logic [1:0] b_c;
    logic [3:0] dst;
    logic       sub;
    logic       first;
  } step_t;

  function automatic step_t mk(input logic [1:0] av, input logic [1:0] ac,
                               input logic [1:0] bs, input logic [1:0] bc,
                               input logic [3:0] d, input logic sb, input logic f);
    step_t s;
    s.a_vec = av; s.a_c = ac; s.b_src = bs; s.b_c = bc;
    s.dst = d; s.sub = sb; s.first = f;
    return s;
  endfunction

  // p = dir x e2, q = s x e1, det = e1.p, un = s.p, vn = dir.q, tn = e2.q
  function automatic step_t step_f(input logic [4:0] k);
    step_t s;
    case (k)
      5'd0:  s = mk(VEC_DIR, CY, B_E2, CZ, DST_P + 4'd0, 1'b0, 1'b1);
      5'd1:  s = mk(VEC_DIR, CZ, B_E2, CY, DST_P + 4'd0, 1'b1, 1'b0);
      5'd2:  s = mk(VEC_DIR, CZ, B_E2, CX, DST_P + 4'd1, 1'b0, 1'b1);
      5'd3:  s = mk(VEC_DIR, CX, B_E2, CZ, DST_P + 4'd1, 1'b1, 1'b0);
      5'd4:  s = mk(VEC_DIR, CX, B_E2, CY, DST_P + 4'd2, 1'b0, 1'b1);
      5'd5:  s = mk(VEC_DIR, CY, B_E2, CX, DST_P + 4'd2, 1'b1, 1'b0);
      5'd6:  s = mk(VEC_S,   CY, B_E1, CZ, DST_Q + 4'd0, 1'b0, 1'b1);
      5'd7:  s = mk(VEC_S,   CZ, B_E1, CY, DST_Q + 4'd0, 1'b1, 1'b0);
      5'd8:  s = mk(VEC_S,   CZ, B_E1, CX, DST_Q + 4'd1, 1'b0, 1'b1);
      5'd9:  s = mk(VEC_S,   CX, B_E1, CZ, DST_Q + 4'd1, 1'b1, 1'b0);
      5'd10: s = mk(VEC_S,   CX, B_E1, CY, DST_Q + 4'd2, 1'b0, 1'b1);
      5'd11: s = mk(VEC_S,   CY, B_E1, CX, DST_Q + 4'd2, 1'b1, 1'b0);
      5'd12: s = mk(VEC_E1,  CX, B_P,  CX, DST_DET, 1'b0, 1'b1);
      5'd13: s = mk(VEC_E1,  CY, B_P,  CY, DST_DET, 1'b0, 1'b0);
      5'd14: s = mk(VEC_E1,  CZ, B_P,  CZ, DST_DET, 1'b0, 1'b0);
      5'd15: s = mk(VEC_S,   CX, B_P,  CX, DST_UN,  1'b0, 1'b1);
      5'd16: s = mk(VEC_S,   CY, B_P,  CY, DST_UN,  1'b0, 1'b0);
      5'd17: s = mk(VEC_S,   CZ, B_P,  CZ, DST_UN,  1'b0, 1'b0);
      5'd18: s = mk(VEC_DIR, CX, B_Q,  CX, DST_VN,  1'b0, 1'b1);
      5'd19: s = mk(VEC_DIR, CY, B_Q,  CY, DST_VN,  1'b0, 1'b0);
      5'd20: s = mk(VEC_DIR, CZ, B_Q,  CZ, DST_VN,  1'b0, 1'b0);
      5'd21: s = mk(VEC_E2,  CX, B_Q,  CX, DST_TN,  1'b0, 1'b1);
      5'd22: s = mk(VEC_E2,  CY, B_Q,  CY, DST_TN,  1'b0, 1'b0);
      5'd23: s = mk(VEC_E2,  CZ, B_Q,  CZ, DST_TN,  1'b0, 1'b0);
      default: s = mk(VEC_DIR, CX, B_E2, CX, DST_P, 1'b0, 1'b1);
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/rti_in_if.sv
// ----------------------------------------------------------------------------
// rti_in_if: request channel
// Valid/ready channel carrying a command and two coordinate triples.
// ----------------------------------------------------------------------------
interface rti_in_if #(
  parameter int CoordBits = 16
) ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic signed [CoordBits-1:0] point_x;
  logic signed [CoordBits-1:0] point_y;
  logic signed [CoordBits-1:0] point_z;
  logic signed [CoordBits-1:0] dir_x;
  logic signed [CoordBits-1:0] dir_y;
  logic signed [CoordBits-1:0] dir_z;

  modport source (output valid, command, point_x, point_y, point_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, command, point_x, point_y, point_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

FILE: hw/rtl/rti_out_if.sv
// ----------------------------------------------------------------------------
// rti_out_if: result channel
// Valid/ready channel carrying the hit flag and the Q16.16 distance.
// ----------------------------------------------------------------------------
interface rti_out_if ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

FILE: hw/rtl/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front: request intake
// Stores vertex loads and turns each ray request into edge and offset
// vectors that are pushed into the queue.
// ----------------------------------------------------------------------------
module rti_front import rti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int EW = COORD_BITS + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rti_in_if.sink          req_i,
  input  logic            full_i,
  output logic            push_o,
  output logic [12*EW-1:0] entry_o
);

  logic signed [COORD_BITS-1:0] va_q [3];
  logic signed [COORD_BITS-1:0] vb_q [3];
  logic signed [COORD_BITS-1:0] vc_q [3];
  logic signed [COORD_BITS-1:0] pt [3];
  logic signed [COORD_BITS-1:0] dr [3];
  logic                         acc;

  assign pt[0] = req_i.point_x;
  assign pt[1] = req_i.point_y;
  assign pt[2] = req_i.point_z;
  assign dr[0] = req_i.dir_x;
  assign dr[1] = req_i.dir_y;
  assign dr[2] = req_i.dir_z;

  assign req_i.ready = !full_i;
  assign acc         = req_i.valid && !full_i;
  assign push_o      = acc && (cmd_e'(req_i.command) == CMD_RAY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        va_q[i] <= '0;
        vb_q[i] <= '0;
        vc_q[i] <= '0;
      end
    end else if (acc) begin
      case (cmd_e'(req_i.command))
        CMD_LOAD_A: for (int i = 0; i < 3; i++) va_q[i] <= pt[i];
        CMD_LOAD_B: for (int i = 0; i < 3; i++) vb_q[i] <= pt[i];
        CMD_LOAD_C: for (int i = 0; i < 3; i++) vc_q[i] <= pt[i];
        default: ;
      endcase
    end
  end

  // Pack dir, e1, e2, s; one slot per vector and component
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      entry_o[(VEC_DIR*3+i)*EW +: EW] = EW'(dr[i]);
      entry_o[(VEC_E1*3+i)*EW +: EW]  = EW'($signed({vb_q[i][COORD_BITS-1], vb_q[i]})
                                          - $signed({va_q[i][COORD_BITS-1], va_q[i]}));
      entry_o[(VEC_E2*3+i)*EW +: EW]  = EW'($signed({vc_q[i][COORD_BITS-1], vc_q[i]})
                                          - $signed({va_q[i][COORD_BITS-1], va_q[i]}));
      entry_o[(VEC_S*3+i)*EW +: EW]   = EW'($signed({pt[i][COORD_BITS-1], pt[i]})
                                          - $signed({va_q[i][COORD_BITS-1], va_q[i]}));
    end
  end

endmodule

FILE: hw/rtl/rti_queue.sv
// ----------------------------------------------------------------------------
// rti_queue: ray queue
// Short FIFO between intake and the arithmetic engine.
// ----------------------------------------------------------------------------
module rti_queue import rti_pkg::*; #(
  parameter int WIDTH = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

FILE: hw/rtl/rti_back.sv
// ----------------------------------------------------------------------------
// rti_back: arithmetic engine
// Runs the product schedule on one shared multiplier, tests the
// barycentric limits, divides for t and holds the result register.
// ----------------------------------------------------------------------------
module rti_back import rti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int EW = COORD_BITS + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [12*EW-1:0] entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  rti_out_if.source        rsp_o
);

  localparam int W  = 3*COORD_BITS + 6;
  localparam int BW = 2*COORD_BITS + 3;
  localparam int PW = EW + BW;
  localparam int RW = W + 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_CHECK  = 6'b000100,
    S_TEST   = 6'b001000,
    S_DIV    = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  state_e               state_q;
  logic signed [EW-1:0] op_q  [12];
  logic signed [W-1:0]  res_q [NUM_RES];
  logic signed [PW-1:0] prod_q;
  step_t                ctl_q;
  logic                 pv_q;
  logic [4:0]           step_q;
  step_t                st;
  logic [3:0]           a_idx, b_idx, bd_idx;
  logic signed [BW-1:0] b_op;

  logic [W-1:0]         dmag_q, tmag_q;
  logic signed [W-1:0]  un_q, vn_q;
  logic                 tneg_q;
  logic [RW-1:0]        rem_q;
  logic [DIV_BITS-1:0]  low_q, quo_q;
  logic [4:0]           cnt_q;
  logic                 rhit_q;
  logic [31:0]          rdist_q;
  logic                 ovalid_q, ohit_q;
  logic [31:0]          odist_q;

  logic signed [W-1:0]  det, tn_s;
  logic                 dneg;
  logic signed [W+1:0]  uv_sum;
  logic [W+15:0]        mag;
  logic [RW-1:0]        rem2;
  logic [DIV_BITS-1:0]  quo_n;

  assign st     = step_f(step_q);
  assign a_idx  = 4'({2'b0, st.a_vec} * 4'd3 + {2'b0, st.a_c});
  assign b_idx  = 4'(((st.b_src == B_E1) ? 4'd3 : 4'd6) + {2'b0, st.b_c});
  assign bd_idx = 4'(((st.b_src == B_P) ? DST_P : DST_Q) + {2'b0, st.b_c});
  assign b_op   = (st.b_src == B_P || st.b_src == B_Q) ? res_q[bd_idx][BW-1:0]
                                                         : BW'(op_q[b_idx]);

  assign pop_o = (state_q == S_IDLE) && !empty_i;

  assign det    = res_q[DST_DET];
  assign dneg   = det[W-1];
  assign tn_s   = dneg ? -res_q[DST_TN] : res_q[DST_TN];
  assign uv_sum = (W+2)'(un_q) + (W+2)'(vn_q);
  assign mag    = {tmag_q, 16'b0};
  assign rem2   = {rem_q[W-1:0], low_q[DIV_BITS-1]};
  assign quo_n  = {quo_q[DIV_BITS-2:0], (rem2 >= RW'(dmag_q))};

  // Multiplier and accumulate: issue a product, add it the next cycle
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < 12; i++) op_q[i] <= entry_i[i*EW +: EW];
    end
    prod_q <= PW'(op_q[a_idx] * b_op);
    ctl_q  <= st;
    if (pv_q) begin
      res_q[ctl_q.dst] <= (ctl_q.first ? W'(0) : res_q[ctl_q.dst])
                        + (ctl_q.sub ? -W'(prod_q) : W'(prod_q));
    end
  end

  // Sign folding, limit test and division datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CHECK: begin
        dmag_q <= dneg ? W'(-det) : W'(det);
        un_q   <= dneg ? -res_q[DST_UN] : res_q[DST_UN];
        vn_q   <= dneg ? -res_q[DST_VN] : res_q[DST_VN];
        tneg_q <= tn_s[W-1];
        tmag_q <= tn_s[W-1] ? W'(-tn_s) : W'(tn_s);
        rhit_q  <= 1'b0;
        rdist_q <= '0;
      end
      S_TEST: begin
        rem_q <= RW'(mag[W+15:DIV_BITS]);
        low_q <= mag[DIV_BITS-1:0];
        quo_q <= '0;
        cnt_q <= 5'(DIV_BITS);
        if (!(un_q[W-1] || vn_q[W-1] || uv_sum > $signed({2'b0, dmag_q}))) begin
          rhit_q  <= 1'b1;
          rdist_q <= tneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
      end
      S_DIV: begin
        rem_q <= (rem2 >= RW'(dmag_q)) ? rem2 - RW'(dmag_q) : rem2;
        low_q <= {low_q[DIV_BITS-2:0], 1'b0};
        quo_q <= quo_n;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 5'd1) begin
          rdist_q <= tneg_q ? 32'(-{1'b0, quo_n}) : {1'b0, quo_n};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      pv_q     <= 1'b0;
      ovalid_q <= 1'b0;
      ohit_q   <= 1'b0;
      odist_q  <= '0;
    end else begin
      if (state_q == S_RESULT && (!ovalid_q || rsp_o.ready)) begin
        ovalid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
      pv_q <= (state_q == S_MUL) && (step_q < 5'(NUM_STEPS));
      case (state_q)
        S_IDLE: begin
          step_q <= '0;
          if (pop_o) state_q <= S_MUL;
        end
        S_MUL: begin
          if (step_q == 5'(NUM_STEPS)) state_q <= S_CHECK;
          else step_q <= step_q + 1'b1;
        end
        S_CHECK: state_q <= (det == '0) ? S_RESULT : S_TEST;
        S_TEST: begin
          if (un_q[W-1] || vn_q[W-1] || uv_sum > $signed({2'b0, dmag_q})) begin
            state_q <= S_RESULT;
          end else if (RW'(mag[W+15:DIV_BITS]) >= RW'(dmag_q)) begin
            state_q <= S_RESULT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: if (cnt_q == 5'd1) state_q <= S_RESULT;
        S_RESULT: begin
          if (!ovalid_q || rsp_o.ready) begin
            ohit_q   <= rhit_q;
            odist_q  <= rdist_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid    = ovalid_q;
  assign rsp_o.hit      = ohit_q;
  assign rsp_o.distance = odist_q;

endmodule

FILE: hw/rtl/ray_triangle_intersect_top.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top: ray/triangle hit test
// Moller-Trumbore intersection of one stored triangle with streamed rays.
// ----------------------------------------------------------------------------
// Send vertex loads (command a, b, c) and ray tests on req_i; each ray test
// returns one response on rsp_o with a hit flag and t in signed Q16.16
// (truncated toward zero, saturated, 0 on a miss; negative t is a hit behind
// the origin). A vertex load produces no response, and rays already queued
// keep the triangle that was loaded when they arrived. After leaving the
// queue, a ray is taken into the operand registers, runs through the shared
// multiplier (24 products plus the last accumulate), then sign folding, the
// limit test and the load of the response register; a zero determinant skips
// the limit test. A hit that does not saturate also passes through the
// bit-serial divider before the response register. Two rays may wait in the
// queue while the engine works, and the response register lets the next ray
// start while a response waits to be taken; a second finished response holds
// the engine until then.
module ray_triangle_intersect_top import rti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rti_in_if.sink     req_i,
  rti_out_if.source  rsp_o
);

  localparam int EW = COORD_BITS + 1;

  logic              push, pop, full, empty;
  logic [12*EW-1:0]  entry_in, entry_out;

  // Intake: hold vertices, form edge vectors for each ray request
  rti_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry_in)
  );

  // Decouple intake from the long arithmetic sequence
  rti_queue #(.WIDTH(12*EW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .pop_i   (pop),
    .data_o  (entry_out),
    .full_o  (full),
    .empty_o (empty)
  );

  // Engine: products, limit test, division, response register
  rti_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (entry_out),
    .empty_i (empty),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule
